### sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while dis is high.
`define ASSERT_IMPLIES(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while dis is high.
`define ASSERT_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/rbd_pkg.sv
// Types and constants of the ring buffer deque.
package rbd_pkg;

  localparam int CMD_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 4;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_READ_AT    = 3'd4,
    CMD_PEEK_FRONT = 3'd5,
    CMD_PEEK_BACK  = 3'd6,
    CMD_NOP        = 3'd7
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_FINISH
  } state_t;

  // Operation broadcast to every cell.
  typedef struct packed {
    logic shift_right;
    logic shift_left;
    logic load_back;
    logic fetch;
  } cell_ctrl_t;

endpackage

### sv/rbd_cmd_if.sv
// Command channel: valid/ready handshake with the command payload.
interface rbd_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [rbd_pkg::CMD_W-1:0]    command;
  logic [rbd_pkg::VALUE_W-1:0]  value;
  logic [rbd_pkg::INDEX_W-1:0]  index;

  modport source (output valid, command, value, index, input ready);
  modport sink   (input valid, command, value, index, output ready);
endinterface

### sv/rbd_rsp_if.sv
// Response channel: valid/ready handshake with the result payload.
interface rbd_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [rbd_pkg::VALUE_W-1:0]   data_out;
  logic [rbd_pkg::STATUS_W-1:0]  status;
  logic [rbd_pkg::COUNT_W-1:0]   count_after;

  modport source (output valid, data_out, status, count_after, input ready);
  modport sink   (input valid, data_out, status, count_after, output ready);
endinterface

### sv/rbd_cell.sv
// One deque cell: holds one element and one stage of the fetch chain.
module rbd_cell #(
  parameter int AW         = 4,
  parameter int DATA_WIDTH = 32,
  parameter int POS        = 0
) (
  input  logic                    clk,
  input  rbd_pkg::cell_ctrl_t     ctrl,
  input  logic [AW-1:0]           wr_pos,
  input  logic [AW-1:0]           fetch_pos,
  input  logic [DATA_WIDTH-1:0]   push_data,
  input  logic [DATA_WIDTH-1:0]   left_data,
  input  logic [DATA_WIDTH-1:0]   right_data,
  input  logic [DATA_WIDTH-1:0]   right_rd,
  output logic [DATA_WIDTH-1:0]   data,
  output logic [DATA_WIDTH-1:0]   rd
);

  localparam logic [AW-1:0] MY_POS = AW'(POS);

  always_ff @(posedge clk) begin
    if (ctrl.shift_right) begin
      data <= left_data;
    end else if (ctrl.shift_left) begin
      data <= right_data;
    end else if (ctrl.load_back && wr_pos == MY_POS) begin
      data <= push_data;
    end
    // the selected cell injects its element, the others pass toward the front
    if (ctrl.fetch) begin
      rd <= (fetch_pos == MY_POS) ? data : right_rd;
    end
  end

endmodule

### sv/ring_buffer_deque.sv
// Top level of the ring buffer deque: control sequencer and the row of cells.
//
// A deque of DEPTH elements of DATA_WIDTH bits kept in a row of cells, front
// element in cell 0. Pushes, no-ops and every command that fails (full, empty,
// index out of range) finish in the idle state: the result is registered at the
// edge the command is accepted. Pops, peeks and read-at bring the addressed
// element to cell 0 over the fetch chain, one cell per cycle, and then register
// it. The walk starts at p, the element's position from the front (0 for pop
// and peek at the front, count - 1 at the back, index for read-at). A new
// command is accepted once the previous one has finished and the result
// register is free or being emptied in the same cycle. No clearing pass is
// needed after reset; cells never written are never read.
module ring_buffer_deque #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst,
  rbd_cmd_if.sink        cmd,
  rbd_rsp_if.source      rsp
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > rbd_pkg::INDEX_W) ? CW : rbd_pkg::INDEX_W;
  localparam int VW   = rbd_pkg::VALUE_W;
  localparam int CAW  = rbd_pkg::COUNT_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  rbd_pkg::state_t     state, state_next;
  rbd_pkg::cmd_t       op, op_next, cmd_op;
  rbd_pkg::cell_ctrl_t ctrl;

  logic [CW-1:0]   count, count_next, count_m1;
  logic [AW-1:0]   fetch_pos, fetch_pos_next;
  logic [AW-1:0]   fetch_cnt, fetch_cnt_next;
  logic [AW-1:0]   wr_pos;
  logic [CMPW-1:0] idx_ext, cnt_ext;
  logic            cmd_fire, full, empty, fetch_start;

  logic                         res_load;
  logic [VW-1:0]                res_data;
  rbd_pkg::status_t             res_status;
  logic                         rsp_valid;
  logic [VW-1:0]                rsp_data;
  logic [rbd_pkg::STATUS_W-1:0] rsp_status;
  logic [CAW-1:0]               rsp_count;

  logic [DATA_WIDTH-1:0] push_data;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH-1:0] cell_rd   [DEPTH];

  assign cmd_op    = rbd_pkg::cmd_t'(cmd.command);
  assign cmd.ready = (state == rbd_pkg::ST_IDLE) && (!rsp_valid || rsp.ready);
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign full      = (count == FULL_CNT);
  assign empty     = (count == '0);
  assign count_m1  = count - CW'(1);
  assign wr_pos    = count[AW-1:0];
  assign idx_ext   = CMPW'(cmd.index);
  assign cnt_ext   = CMPW'(count);
  assign push_data = DATA_WIDTH'(cmd.value);

  // Decode and per-state control.
  always_comb begin
    ctrl           = '0;
    res_load       = 1'b0;
    res_data       = '0;
    res_status     = rbd_pkg::STAT_OK;
    count_next     = count;
    fetch_pos_next = fetch_pos;
    fetch_cnt_next = fetch_cnt;
    op_next        = op;
    fetch_start    = 1'b0;
    case (state)
      rbd_pkg::ST_IDLE: begin
        if (cmd_fire) begin
          op_next = cmd_op;
          case (cmd_op)
            rbd_pkg::CMD_PUSH_FRONT, rbd_pkg::CMD_PUSH_BACK: begin
              res_load = 1'b1;
              if (full) begin
                res_status = rbd_pkg::STAT_FULL;
              end else begin
                ctrl.shift_right = (cmd_op == rbd_pkg::CMD_PUSH_FRONT);
                ctrl.load_back   = (cmd_op == rbd_pkg::CMD_PUSH_BACK);
                count_next       = count + CW'(1);
              end
            end
            rbd_pkg::CMD_POP_FRONT, rbd_pkg::CMD_PEEK_FRONT: begin
              if (empty) begin
                res_load   = 1'b1;
                res_status = rbd_pkg::STAT_EMPTY;
              end else begin
                fetch_start    = 1'b1;
                fetch_pos_next = '0;
                fetch_cnt_next = '0;
              end
            end
            rbd_pkg::CMD_POP_BACK, rbd_pkg::CMD_PEEK_BACK: begin
              if (empty) begin
                res_load   = 1'b1;
                res_status = rbd_pkg::STAT_EMPTY;
              end else begin
                fetch_start    = 1'b1;
                fetch_pos_next = count_m1[AW-1:0];
                fetch_cnt_next = count_m1[AW-1:0];
              end
            end
            rbd_pkg::CMD_READ_AT: begin
              if (idx_ext >= cnt_ext) begin
                res_load   = 1'b1;
                res_status = rbd_pkg::STAT_RANGE;
              end else begin
                fetch_start    = 1'b1;
                fetch_pos_next = idx_ext[AW-1:0];
                fetch_cnt_next = idx_ext[AW-1:0];
              end
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      rbd_pkg::ST_FETCH: begin
        ctrl.fetch = 1'b1;
        if (fetch_cnt != '0) begin
          fetch_cnt_next = fetch_cnt - AW'(1);
        end
      end
      rbd_pkg::ST_FINISH: begin
        res_load = 1'b1;
        res_data = VW'(cell_rd[0]);
        if (op == rbd_pkg::CMD_POP_FRONT) begin
          ctrl.shift_left = 1'b1;
          count_next      = count_m1;
        end else if (op == rbd_pkg::CMD_POP_BACK) begin
          count_next = count_m1;
        end
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      rbd_pkg::ST_IDLE: begin
        if (fetch_start) begin
          state_next = rbd_pkg::ST_FETCH;
        end
      end
      rbd_pkg::ST_FETCH: begin
        if (fetch_cnt == '0) begin
          state_next = rbd_pkg::ST_FINISH;
        end
      end
      rbd_pkg::ST_FINISH: begin
        state_next = rbd_pkg::ST_IDLE;
      end
      default: begin
        state_next = rbd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rbd_pkg::ST_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (res_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    fetch_pos <= fetch_pos_next;
    fetch_cnt <= fetch_cnt_next;
    op        <= op_next;
    if (res_load) begin
      rsp_data   <= res_data;
      rsp_status <= res_status;
      rsp_count  <= CAW'(count_next);
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.data_out    = rsp_data;
  assign rsp.status      = rsp_status;
  assign rsp.count_after = rsp_count;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_data, right_data, right_rd;

    if (k == 0) begin : g_first
      assign left_data = push_data;
    end else begin : g_mid_left
      assign left_data = cell_data[k-1];
    end

    if (k == DEPTH - 1) begin : g_last
      assign right_data = cell_data[k];
      assign right_rd   = '0;
    end else begin : g_mid_right
      assign right_data = cell_data[k+1];
      assign right_rd   = cell_rd[k+1];
    end

    rbd_cell #(
      .AW         (AW),
      .DATA_WIDTH (DATA_WIDTH),
      .POS        (k)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .wr_pos     (wr_pos),
      .fetch_pos  (fetch_pos),
      .push_data  (push_data),
      .left_data  (left_data),
      .right_data (right_data),
      .right_rd   (right_rd),
      .data       (cell_data[k]),
      .rd         (cell_rd[k])
    );
  end

endmodule

### sv/rbd_checker.sv
// Port-level checker for the ring buffer deque, bound to the top level.
`include "assert_macros.svh"

module rbd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          cmd_valid,
  input logic                          cmd_ready,
  input logic [rbd_pkg::CMD_W-1:0]     cmd_command,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [rbd_pkg::VALUE_W-1:0]   data_out,
  input logic [rbd_pkg::STATUS_W-1:0]  status,
  input logic [rbd_pkg::COUNT_W-1:0]   count_after
);

  logic                            cmd_fire, rsp_fire, last_push;
  logic [rbd_pkg::COUNT_W-1:0]     last_cnt;

  assign cmd_fire = cmd_valid && cmd_ready;
  assign rsp_fire = rsp_valid && rsp_ready;

  // track the command in flight and the last count delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      last_push <= 1'b0;
      last_cnt  <= '0;
    end else begin
      if (cmd_fire) begin
        last_push <= (cmd_command == rbd_pkg::CMD_PUSH_FRONT) ||
                     (cmd_command == rbd_pkg::CMD_PUSH_BACK);
      end
      if (rsp_fire) begin
        last_cnt <= count_after;
      end
    end
  end

  `ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(data_out) && $stable(status) && $stable(count_after))
  `ASSERT_IMPLIES(a_fail_zero, clk, rst, rsp_valid && status != rbd_pkg::STAT_OK, data_out == '0)
  `ASSERT_IMPLIES(a_fail_keeps_count, clk, rst, rsp_fire && status != rbd_pkg::STAT_OK, count_after == last_cnt)
  `ASSERT_IMPLIES(a_full_on_push, clk, rst, rsp_fire && status == rbd_pkg::STAT_FULL, last_push)
  `ASSERT_NEXT(a_reset_idle, clk, 1'b0, rst, !rsp_valid)

endmodule

bind ring_buffer_deque rbd_checker u_rbd_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_valid   (cmd.valid),
  .cmd_ready   (cmd.ready),
  .cmd_command (cmd.command),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .data_out    (rsp.data_out),
  .status      (rsp.status),
  .count_after (rsp.count_after)
);
